@@ rtl/mcd_pkg.sv @@
`default_nettype none

package mcd_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned CntW    = 4;
  localparam int unsigned SumW    = 4;
  localparam int unsigned DigitW  = 4;
  localparam int unsigned StatusW = 2;
  localparam int unsigned TdataOW = 8;

  localparam logic [CntW-1:0]  LenMin     = 4'd11;
  localparam logic [CntW-1:0]  LenMax     = 4'd14;
  localparam logic [CntW-1:0]  DigitsUsed = 4'd10;
  localparam logic [CntW-1:0]  CharsSat   = 4'd15;
  localparam logic [ByteW-1:0] AsciiSpace = 8'h20;
  localparam logic [ByteW-1:0] AsciiZero  = 8'h30;
  localparam logic [ByteW-1:0] AsciiNine  = 8'h39;

  typedef enum logic [StatusW-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_BAD_CHECK = 2'd1,
    STATUS_MALFORMED = 2'd2
  } mcd_status_e;

  typedef struct packed {
    logic [DigitW-1:0] expected_digit;
    mcd_status_e       status;
  } mcd_res_t;

  // MOD 11,10 step: ((((sum + d + 9) mod 10) + 1) * 2) mod 11, sum in 0..10, d in 0..9
  function automatic logic [SumW-1:0] mcd_step(input logic [SumW-1:0] sum,
                                               input logic [DigitW-1:0] d);
    logic [4:0] t;
    logic [4:0] m;
    logic [4:0] p;
    t = 5'(sum) + 5'(d) + 5'd9;
    if (t >= 5'd20) begin
      m = t - 5'd20;
    end else if (t >= 5'd10) begin
      m = t - 5'd10;
    end else begin
      m = t;
    end
    p = 5'((m + 5'd1) << 1);
    if (p >= 5'd11) begin
      p = p - 5'd11;
    end
    return p[SumW-1:0];
  endfunction

  // (11 - sum) mod 10
  function automatic logic [DigitW-1:0] mcd_expect(input logic [SumW-1:0] sum);
    logic [4:0] t;
    t = 5'd11 - 5'(sum);
    if (t >= 5'd10) begin
      t = t - 5'd10;
    end
    return t[DigitW-1:0];
  endfunction

endpackage

`default_nettype wire

@@ rtl/mcd_scan.sv @@
`default_nettype none

module mcd_scan (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        accept_i,
  input  wire logic [mcd_pkg::ByteW-1:0]   char_i,
  input  wire logic                        last_i,
  output logic                             res_valid_o,
  output mcd_pkg::mcd_res_t                res_o
);

  logic [mcd_pkg::SumW-1:0] sum_q, sum_d;
  logic [mcd_pkg::CntW-1:0] digits_q, digits_d;
  logic [mcd_pkg::CntW-1:0] chars_q, chars_d;
  logic                     ferr_q, ferr_d;

  logic                       is_digit;
  logic [mcd_pkg::DigitW-1:0] digit;
  logic [mcd_pkg::DigitW-1:0] expect_dig;
  logic [mcd_pkg::ByteW-1:0]  char_diff;

  assign char_diff = char_i - mcd_pkg::AsciiZero;
  assign digit     = char_diff[mcd_pkg::DigitW-1:0];
  assign is_digit  = (char_i >= mcd_pkg::AsciiZero) && (char_i <= mcd_pkg::AsciiNine);

  always_comb begin
    sum_d    = sum_q;
    digits_d = digits_q;
    ferr_d   = ferr_q;
    chars_d  = (chars_q < mcd_pkg::CharsSat) ? chars_q + 4'd1 : chars_q;
    if ((digits_q < mcd_pkg::DigitsUsed) && (char_i != mcd_pkg::AsciiSpace)) begin
      if (is_digit) begin
        sum_d    = mcd_pkg::mcd_step(sum_q, digit);
        digits_d = digits_q + 4'd1;
      end else begin
        ferr_d = 1'b1;
      end
    end
  end

  assign expect_dig = mcd_pkg::mcd_expect(sum_d);

  always_comb begin
    res_valid_o = accept_i && last_i;
    if ((chars_d < mcd_pkg::LenMin) || (chars_d > mcd_pkg::LenMax) || ferr_d) begin
      res_o.status         = mcd_pkg::STATUS_MALFORMED;
      res_o.expected_digit = '0;
    end else begin
      res_o.expected_digit = expect_dig;
      if (char_i == (mcd_pkg::AsciiZero + mcd_pkg::ByteW'(expect_dig))) begin
        res_o.status = mcd_pkg::STATUS_OK;
      end else begin
        res_o.status = mcd_pkg::STATUS_BAD_CHECK;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q    <= '0;
      digits_q <= '0;
      chars_q  <= '0;
      ferr_q   <= 1'b0;
    end else if (accept_i) begin
      if (last_i) begin
        sum_q    <= '0;
        digits_q <= '0;
        chars_q  <= '0;
        ferr_q   <= 1'b0;
      end else begin
        sum_q    <= sum_d;
        digits_q <= digits_d;
        chars_q  <= chars_d;
        ferr_q   <= ferr_d;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/mcd_out.sv @@
`default_nettype none

module mcd_out (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        res_valid_i,
  input  wire mcd_pkg::mcd_res_t res_i,
  output logic             can_take_o,
  output logic             valid_o,
  input  wire logic        ready_i,
  output mcd_pkg::mcd_res_t res_o
);

  logic              valid_q;
  mcd_pkg::mcd_res_t res_q;

  assign can_take_o = !valid_q || ready_i;
  assign valid_o    = valid_q;
  assign res_o      = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (can_take_o) begin
      valid_q <= res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (can_take_o && res_valid_i) begin
      res_q <= res_i;
    end
  end

endmodule

`default_nettype wire

@@ rtl/mod11_10_check_digit_stream_unit.sv @@
// ISO 7064 MOD 11,10 checker for an identifier streamed one ASCII byte per word, tlast on
// the final (check digit) byte. Spaces are skipped; the first ten digits feed the running
// sum; any other character before the tenth digit marks the identifier malformed, as does
// a length (all bytes, saturating at 15) outside 11..14. One word per cycle is taken while
// the output register is empty or being drained; each tlast word yields one result word,
// registered and shown from the next cycle, after which the state is clear for the next identifier.
`default_nettype none

module mod11_10_check_digit_stream_unit (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  wire logic [7:0]                   s_axis_tdata_i,  // [7:0] char_byte
  input  wire logic                         s_axis_tlast_i,  // is_last
  output logic                              m_axis_tvalid_o,
  input  wire logic                         m_axis_tready_i,
  output logic [mcd_pkg::TdataOW-1:0]       m_axis_tdata_o   // [1:0] status, [5:2] expected_digit
);

  logic              accept;
  logic              res_valid;
  mcd_pkg::mcd_res_t res;
  mcd_pkg::mcd_res_t out_res;

  assign accept = s_axis_tvalid_i && s_axis_tready_o;

  mcd_scan u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .char_i      (s_axis_tdata_i),
    .last_i      (s_axis_tlast_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  mcd_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .can_take_o  (s_axis_tready_o),
    .valid_o     (m_axis_tvalid_o),
    .ready_i     (m_axis_tready_i),
    .res_o       (out_res)
  );

  assign m_axis_tdata_o = {2'b00, out_res.expected_digit, out_res.status};

endmodule

`default_nettype wire

@@ rtl/mcd_checker.sv @@
`default_nettype none

module mcd_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       m_axis_tvalid_o,
  input wire logic       m_axis_tready_i,
  input wire logic [7:0] m_axis_tdata_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result word changed while stalled");

  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[1:0] != 2'd3)
    else $error("status code out of range");

  a_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[5:2] <= 4'd9)
    else $error("expected digit out of range");

  a_malformed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tdata_o[1:0] == mcd_pkg::STATUS_MALFORMED)
      |-> m_axis_tdata_o[5:2] == 4'd0)
    else $error("malformed result with non-zero digit");

  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[7:6] == 2'b00)
    else $error("padding bits not zero");

endmodule

bind mod11_10_check_digit_stream_unit mcd_checker u_mcd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

`default_nettype wire

@@ dv/mcd_verdict_monitor.sv @@
`timescale 1ns / 100ps

module mcd_verdict_monitor (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        s_tvalid_i,
  input  wire logic                        s_tready_i,
  input  wire logic [7:0]                  s_tdata_i,
  input  wire logic                        s_tlast_i,
  input  wire logic                        m_tvalid_i,
  input  wire logic                        m_tready_i,
  input  wire logic [mcd_pkg::TdataOW-1:0] m_tdata_i,
  output int                               mismatch_cnt_o,
  output int                               outstanding_o,
  output int                               n_ok_o,
  output int                               n_bad_check_o,
  output int                               n_malformed_o
);

  logic [3:0]       fold_sum;
  logic [3:0]       digit_cnt;
  logic [3:0]       byte_cnt;
  logic             bad_char;
  mcd_pkg::mcd_res_t verdict_q[$];
  mcd_pkg::mcd_res_t want;
  mcd_pkg::mcd_res_t next_verdict;
  logic [1:0]       got_status;
  logic [3:0]       got_digit;
  logic [7:0]       check_char;

  // one MOD 11,10 step on a decimal digit
  function automatic logic [3:0] mod1110_fold(input logic [3:0] acc, input logic [3:0] d);
    int t;
    t = (int'(acc) + int'(d) + 9) % 10 + 1;
    return 4'((t * 2) % 11);
  endfunction

  initial begin
    mismatch_cnt_o = 0;
    outstanding_o  = 0;
    n_ok_o         = 0;
    n_bad_check_o  = 0;
    n_malformed_o  = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fold_sum  = '0;
      digit_cnt = '0;
      byte_cnt  = '0;
      bad_char  = 1'b0;
      verdict_q.delete();
      outstanding_o <= 0;
    end else begin
      // result words first: a verdict never leaves in the cycle its tlast word enters
      if (m_tvalid_i && m_tready_i) begin
        got_status = m_tdata_i[1:0];
        got_digit  = m_tdata_i[5:2];
        if (verdict_q.size() == 0) begin
          mismatch_cnt_o++;
          $display("%0t: unexpected result word, expected none, actual %h", $time, m_tdata_i);
        end else begin
          want = verdict_q.pop_front();
          if (got_status != want.status || got_digit != want.expected_digit ||
              m_tdata_i[7:6] != 2'b00) begin
            mismatch_cnt_o++;
            $display("%0t: mismatch, expected status %0d digit %0d, actual status %0d digit %0d pad %0d",
                     $time, want.status, want.expected_digit, got_status, got_digit,
                     m_tdata_i[7:6]);
          end
          case (want.status)
            mcd_pkg::STATUS_OK:        n_ok_o++;
            mcd_pkg::STATUS_BAD_CHECK: n_bad_check_o++;
            default:                   n_malformed_o++;
          endcase
        end
      end

      if (s_tvalid_i && s_tready_i) begin
        if (byte_cnt != mcd_pkg::CharsSat) begin
          byte_cnt = byte_cnt + 4'd1;
        end
        if (digit_cnt < mcd_pkg::DigitsUsed && s_tdata_i != mcd_pkg::AsciiSpace) begin
          if (s_tdata_i >= mcd_pkg::AsciiZero && s_tdata_i <= mcd_pkg::AsciiNine) begin
            fold_sum  = mod1110_fold(fold_sum, s_tdata_i[3:0]);
            digit_cnt = digit_cnt + 4'd1;
          end else begin
            bad_char = 1'b1;
          end
        end
        if (s_tlast_i) begin
          if (byte_cnt < mcd_pkg::LenMin || byte_cnt > mcd_pkg::LenMax || bad_char) begin
            next_verdict.status         = mcd_pkg::STATUS_MALFORMED;
            next_verdict.expected_digit = '0;
          end else begin
            next_verdict.expected_digit = 4'((11 - int'(fold_sum)) % 10);
            check_char = mcd_pkg::AsciiZero + {4'd0, next_verdict.expected_digit};
            next_verdict.status = (s_tdata_i == check_char) ? mcd_pkg::STATUS_OK
                                                            : mcd_pkg::STATUS_BAD_CHECK;
          end
          verdict_q.push_back(next_verdict);
          fold_sum  = '0;
          digit_cnt = '0;
          byte_cnt  = '0;
          bad_char  = 1'b0;
        end
      end
      outstanding_o <= verdict_q.size();
    end
  end

endmodule

@@ dv/tb_mod11_10_check_digit_stream_unit.sv @@
`timescale 1ns / 100ps

module tb_mod11_10_check_digit_stream_unit;

  localparam int NumWords      = 1450;
  localparam int WatchdogLimit = 4000;

  logic                        clk_i;
  logic                        rst_ni          = 1'b0;
  logic                        s_axis_tvalid_i = 1'b0;
  logic [7:0]                  s_axis_tdata_i  = 8'h00;
  logic                        s_axis_tlast_i  = 1'b0;
  logic                        m_axis_tready_i = 1'b0;
  logic                        s_axis_tready_o;
  logic                        m_axis_tvalid_o;
  logic [mcd_pkg::TdataOW-1:0] m_axis_tdata_o;

  int mismatch_cnt;
  int outstanding;
  int n_ok;
  int n_bad_check;
  int n_malformed;

  logic [7:0] id_bytes[$];
  int         burst_left = 0;
  bit         no_gaps    = 1'b0;
  int         words_sent = 0;
  int         idents     = 0;
  int         idle_cycles = 0;
  int         cyc = 0;
  int         rx_mode = 0;
  int         rx_hold = 0;

  mod11_10_check_digit_stream_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  mcd_verdict_monitor u_verdicts (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_tvalid_i     (s_axis_tvalid_i),
    .s_tready_i     (s_axis_tready_o),
    .s_tdata_i      (s_axis_tdata_i),
    .s_tlast_i      (s_axis_tlast_i),
    .m_tvalid_i     (m_axis_tvalid_o),
    .m_tready_i     (m_axis_tready_i),
    .m_tdata_i      (m_axis_tdata_o),
    .mismatch_cnt_o (mismatch_cnt),
    .outstanding_o  (outstanding),
    .n_ok_o         (n_ok),
    .n_bad_check_o  (n_bad_check),
    .n_malformed_o  (n_malformed)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // receiver: ready pattern switches between modes every so often
  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (rx_hold == 0) begin
      rx_mode <= $urandom_range(0, 3);
      rx_hold <= $urandom_range(20, 200);
    end else begin
      rx_hold <= rx_hold - 1;
    end
    case (rx_mode)
      0:       m_axis_tready_i <= 1'b1;
      1:       m_axis_tready_i <= 1'($urandom_range(0, 1));
      2:       m_axis_tready_i <= ($urandom_range(0, 3) == 0);
      default: m_axis_tready_i <= (cyc % 5 != 0);
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WatchdogLimit) begin
        $display("watchdog: no word moved for %0d cycles", WatchdogLimit);
        $display("tb_mod11_10_check_digit_stream_unit: done, errors");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic push_word(input logic [7:0] b, input logic last);
    int gap;
    if (burst_left == 0) begin
      gap = no_gaps ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
        s_axis_tvalid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    s_axis_tlast_i  <= last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    words_sent++;
  endtask

  task automatic send_ident();
    foreach (id_bytes[i]) begin
      push_word(id_bytes[i], i == id_bytes.size() - 1);
    end
    idents++;
  endtask

  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (outstanding != 0);
  endtask

  function automatic logic [7:0] any_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  // correct check character for the digits queued so far
  function automatic logic [7:0] true_check_char();
    int acc;
    int n;
    int t;
    acc = 0;
    n   = 0;
    foreach (id_bytes[i]) begin
      if (n < 10 && id_bytes[i] >= mcd_pkg::AsciiZero && id_bytes[i] <= mcd_pkg::AsciiNine) begin
        t   = (acc + int'(id_bytes[i] - mcd_pkg::AsciiZero) + 9) % 10 + 1;
        acc = (t * 2) % 11;
        n++;
      end
    end
    return mcd_pkg::AsciiZero + 8'((11 - acc) % 10);
  endfunction

  // flaw: 0 clean, 1 bad character, 2 too long, 3 too few digits
  task automatic build_ident(input int flaw);
    int         n_dig;
    int         sp_left;
    int         tail;
    int         bad_at;
    logic [7:0] b;
    id_bytes.delete();
    n_dig   = (flaw == 3) ? $urandom_range(0, 9) : 10;
    sp_left = $urandom_range(0, 2);
    tail    = (flaw == 2) ? $urandom_range(4, 8) : $urandom_range(0, 1);
    bad_at  = (flaw == 1) ? $urandom_range(0, 9) : -1;
    for (int i = 0; i < n_dig; i++) begin
      if (sp_left > 0 && $urandom_range(0, 3) == 0) begin
        id_bytes.push_back(mcd_pkg::AsciiSpace);
        sp_left--;
      end
      if (i == bad_at) begin
        do b = any_byte();
        while (b == mcd_pkg::AsciiSpace ||
               (b >= mcd_pkg::AsciiZero && b <= mcd_pkg::AsciiNine));
        id_bytes.push_back(b);
      end else begin
        id_bytes.push_back(mcd_pkg::AsciiZero + 8'($urandom_range(0, 9)));
      end
    end
    repeat (sp_left) id_bytes.push_back(mcd_pkg::AsciiSpace);
    repeat (tail) id_bytes.push_back(any_byte());
    if (flaw == 0 && $urandom_range(0, 1) == 1) begin
      id_bytes.push_back(true_check_char());
    end else if ($urandom_range(0, 9) == 0) begin
      id_bytes.push_back(any_byte());
    end else begin
      id_bytes.push_back(mcd_pkg::AsciiZero + 8'($urandom_range(0, 9)));
    end
  endtask

  initial begin
    int r;
    bit drained_mid;
    drained_mid = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // lone final bytes at both byte extremes
    id_bytes = '{8'h00};
    send_ident();
    id_bytes = '{8'hff};
    send_ident();
    // ten zeros give check digit 1
    id_bytes.delete();
    repeat (10) id_bytes.push_back(mcd_pkg::AsciiZero);
    id_bytes.push_back(mcd_pkg::AsciiZero + 8'd1);
    send_ident();
    // embedded space, non-digit check character
    id_bytes.delete();
    repeat (5) id_bytes.push_back(mcd_pkg::AsciiZero);
    id_bytes.push_back(mcd_pkg::AsciiSpace);
    repeat (5) id_bytes.push_back(mcd_pkg::AsciiZero);
    id_bytes.push_back(mcd_pkg::AsciiNine + 8'd1);
    send_ident();
    drain();

    while (words_sent < NumWords) begin
      if (idents % 16 == 0) begin
        no_gaps = ($urandom_range(0, 3) == 0);
      end
      r = $urandom_range(0, 99);
      if (r < 70) begin
        build_ident(0);
      end else if (r < 78) begin
        build_ident(1);
      end else if (r < 84) begin
        build_ident(2);
      end else if (r < 90) begin
        build_ident(3);
      end else begin
        id_bytes.delete();
        repeat ($urandom_range(1, 20)) id_bytes.push_back(any_byte());
      end
      send_ident();
      if (!drained_mid && words_sent > NumWords / 2) begin
        drained_mid = 1'b1;
        drain();
      end
    end

    drain();
    repeat (8) @(posedge clk_i);
    $display("run: %0d words in %0d identifiers, mixed clean, flawed and noise strings",
             words_sent, idents);
    $display("results: %0d conformant, %0d wrong check digit, %0d malformed",
             n_ok, n_bad_check, n_malformed);
    if (mismatch_cnt == 0) begin
      $display("tb_mod11_10_check_digit_stream_unit: done, clean");
    end else begin
      $display("tb_mod11_10_check_digit_stream_unit: done, errors");
    end
    $finish;
  end

endmodule
